@@ hdl/dmxtx_pkg.sv @@
// ----------------------------------------------------------------------------
// dmxtx_pkg
// Shared types and constants for the DMX512 frame transmitter.
// ----------------------------------------------------------------------------
package dmxtx_pkg;

  // slot store geometry
  localparam int SLOTS   = 513;
  localparam int SLOT_AW = 10;
  localparam logic [SLOT_AW-1:0] SLOT_NUM  = SLOT_AW'(SLOTS);
  localparam logic [SLOT_AW-1:0] SLOT_LAST = SLOT_AW'(SLOTS - 1);

  // request kinds
  typedef enum logic [1:0] {
    KIND_TICK     = 2'd0,
    KIND_WRITE    = 2'd1,
    KIND_ENABLE   = 2'd2,
    KIND_BLACKOUT = 2'd3
  } kind_t;

  // configuration register indexes
  localparam logic [2:0] REG_SLOT_COUNT   = 3'd0;
  localparam logic [2:0] REG_BREAK_RELOAD = 3'd1;
  localparam logic [2:0] REG_MAB_RELOAD   = 3'd2;
  localparam logic [2:0] REG_BIT_RELOAD   = 3'd3;
  localparam logic [2:0] REG_STOP_RELOAD  = 3'd4;

  // configuration reset values
  localparam logic [9:0] RST_SLOT_COUNT   = 10'd513;
  localparam logic [7:0] RST_BREAK_RELOAD = 8'd20;
  localparam logic [7:0] RST_MAB_RELOAD   = 8'd220;
  localparam logic [7:0] RST_BIT_RELOAD   = 8'd249;
  localparam logic [7:0] RST_STOP_RELOAD  = 8'd239;

  // configuration as seen by the frame engine
  typedef struct packed {
    logic [SLOT_AW-1:0] count;
    logic [7:0]         break_reload;
    logic [7:0]         mab_reload;
    logic [7:0]         bit_reload;
    logic [7:0]         stop_reload;
  } cfg_t;

  typedef struct packed {
    logic               en;
    logic [SLOT_AW-1:0] addr;
  } mem_rd_t;

  typedef struct packed {
    logic               en;
    logic [SLOT_AW-1:0] addr;
    logic [7:0]         data;
  } mem_wr_t;

  typedef struct packed {
    logic       line_level;
    logic       indicator;
    logic [7:0] interval_reload;
  } result_t;

endpackage

@@ hdl/dmxtx_slot_mem.sv @@
// ----------------------------------------------------------------------------
// dmxtx_slot_mem
// Slot value store with a clearing sweep after reset and a registered read.
// ----------------------------------------------------------------------------
module dmxtx_slot_mem (
  input  logic                     clk,
  input  logic                     rst,
  input  dmxtx_pkg::mem_wr_t       wr,
  input  dmxtx_pkg::mem_rd_t       rd,
  output logic [7:0]               rd_data,
  output logic                     clearing
);
  import dmxtx_pkg::*;

  logic [7:0]         store [SLOTS];
  logic [SLOT_AW-1:0] clr_addr;
  logic [7:0]         rdata;
  logic               rd_oob;

  // sweep every entry to zero once after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == SLOT_LAST) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      store[clr_addr] <= 8'd0;
    end else if (wr.en) begin
      store[wr.addr] <= wr.data;
    end
  end

  // out of range slots read as zero
  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_oob <= (rd.addr >= SLOT_NUM);
      if (rd.addr < SLOT_NUM) begin
        rdata <= store[rd.addr];
      end
    end
  end

  assign rd_data = rd_oob ? 8'd0 : rdata;

  a_no_write_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !wr.en)
    else $error("slot write during clearing sweep");

endmodule

@@ hdl/dmxtx_out_buf.sv @@
// ----------------------------------------------------------------------------
// dmxtx_out_buf
// Output register with a skid stage for the tick results.
// ----------------------------------------------------------------------------
module dmxtx_out_buf (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  dmxtx_pkg::result_t  push_data,
  output logic                full,
  output logic                out_valid,
  input  logic                out_ready,
  output dmxtx_pkg::result_t  out_data
);
  import dmxtx_pkg::*;

  result_t skid_data;
  logic    skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid  <= skid_valid || push;
      skid_valid <= skid_valid && push;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      out_data <= skid_valid ? skid_data : push_data;
      if (skid_valid && push) begin
        skid_data <= push_data;
      end
    end else if (push) begin
      skid_data <= push_data;
    end
  end

  assign full = skid_valid;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid holds a result while output register is empty");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> !push)
    else $error("result pushed into a full buffer");

endmodule

@@ hdl/dmxtx_engine.sv @@
// ----------------------------------------------------------------------------
// dmxtx_engine
// Frame sequencer: break, mark after break, then start, data and stop per slot.
// ----------------------------------------------------------------------------
module dmxtx_engine (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  dmxtx_pkg::kind_t              kind,
  input  logic                          flag,
  input  dmxtx_pkg::cfg_t               cfg,
  input  logic [7:0]                    rd_data,
  output dmxtx_pkg::mem_rd_t            rd,
  output logic                          push,
  output dmxtx_pkg::result_t            push_data
);
  import dmxtx_pkg::*;

  typedef enum logic [5:0] {
    PH_IDLE  = 6'b000001,
    PH_START = 6'b000010,
    PH_DATA  = 6'b000100,
    PH_STOP  = 6'b001000,
    PH_BREAK = 6'b010000,
    PH_MAB   = 6'b100000
  } phase_t;

  phase_t             phase, phase_next;
  logic [3:0]         bits_left, bits_left_next;
  logic [SLOT_AW-1:0] slot_counter, slot_counter_next;
  logic [7:0]         shift_byte, shift_byte_next;
  logic               use_mem, use_mem_next;
  logic               pending_level, pending_level_next;
  logic               pending_indicator, pending_indicator_next;
  logic [7:0]         pending_reload, pending_reload_next;
  logic               blackout_on, blackout_on_next;

  logic               tick;
  logic [7:0]         cur_byte;
  logic [SLOT_AW-1:0] start_count;
  logic [SLOT_AW-1:0] dec_count;
  logic [3:0]         dec_bits;

  assign tick        = accept && (kind == KIND_TICK);
  // first data bit comes straight from the store read
  assign cur_byte    = use_mem ? rd_data : shift_byte;
  assign start_count = (slot_counter == '0) ? cfg.count : slot_counter;
  assign dec_count   = slot_counter - 1'b1;
  assign dec_bits    = bits_left - 1'b1;

  assign rd.en   = tick && (phase == PH_START);
  assign rd.addr = cfg.count - start_count;

  assign push                      = tick;
  assign push_data.line_level      = pending_level;
  assign push_data.indicator       = pending_indicator;
  assign push_data.interval_reload = pending_reload;

  always_comb begin
    phase_next             = phase;
    bits_left_next         = bits_left;
    slot_counter_next      = slot_counter;
    shift_byte_next        = shift_byte;
    use_mem_next           = use_mem;
    pending_level_next     = pending_level;
    pending_indicator_next = pending_indicator;
    pending_reload_next    = pending_reload;
    blackout_on_next       = blackout_on;
    if (accept) begin
      case (kind)
        KIND_TICK: begin
          case (phase)
            PH_DATA: begin
              pending_level_next  = blackout_on ? 1'b0 : cur_byte[0];
              shift_byte_next     = {1'b0, cur_byte[7:1]};
              use_mem_next        = 1'b0;
              pending_reload_next = cfg.bit_reload;
              bits_left_next      = dec_bits;
              if (dec_bits == 4'd0) begin
                phase_next = PH_STOP;
              end
            end
            PH_STOP: begin
              pending_level_next  = 1'b1;
              pending_reload_next = cfg.stop_reload;
              if (dec_count == '0) begin
                slot_counter_next = cfg.count;
                phase_next        = PH_BREAK;
              end else begin
                slot_counter_next = dec_count;
                phase_next        = PH_START;
              end
            end
            PH_START: begin
              slot_counter_next      = start_count;
              use_mem_next           = 1'b1;
              pending_level_next     = 1'b0;
              pending_indicator_next = 1'b0;
              pending_reload_next    = cfg.bit_reload;
              bits_left_next         = 4'd8;
              phase_next             = PH_DATA;
            end
            PH_BREAK: begin
              pending_level_next  = 1'b0;
              pending_reload_next = cfg.break_reload;
              phase_next          = PH_MAB;
            end
            PH_MAB: begin
              pending_level_next     = 1'b1;
              pending_indicator_next = 1'b1;
              pending_reload_next    = cfg.mab_reload;
              phase_next             = PH_START;
            end
            default: begin
              pending_reload_next = cfg.mab_reload;
            end
          endcase
        end
        KIND_ENABLE: begin
          phase_next = flag ? PH_START : PH_IDLE;
        end
        KIND_BLACKOUT: begin
          blackout_on_next = flag;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_IDLE;
      bits_left         <= 4'd0;
      slot_counter      <= '0;
      shift_byte        <= 8'd0;
      use_mem           <= 1'b0;
      pending_level     <= 1'b1;
      pending_indicator <= 1'b1;
      pending_reload    <= 8'd0;
      blackout_on       <= 1'b0;
    end else begin
      phase             <= phase_next;
      bits_left         <= bits_left_next;
      slot_counter      <= slot_counter_next;
      shift_byte        <= shift_byte_next;
      use_mem           <= use_mem_next;
      pending_level     <= pending_level_next;
      pending_indicator <= pending_indicator_next;
      pending_reload    <= pending_reload_next;
      blackout_on       <= blackout_on_next;
    end
  end

  a_data_has_bits: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DATA) |-> (bits_left != 4'd0) && (slot_counter != '0))
    else $error("data phase with no bits or no slot count");

  a_start_to_data: assert property (@(posedge clk) disable iff (rst)
    (tick && phase == PH_START) |=> (phase == PH_DATA) && use_mem)
    else $error("start bit did not lead into data bits");

endmodule

@@ hdl/dmx512_frame_transmitter.sv @@
// ----------------------------------------------------------------------------
// dmx512_frame_transmitter
// DMX512 frame generator driven by timer tick requests.
// ----------------------------------------------------------------------------
// result: a tick request's result is registered into the output register, or into the skid
//   stage while the output stalls; writes, enable and blackout requests give no result
// throughput: one request per cycle, limited by the clearing sweep and the two-entry output stage
// reset: synchronous; after reset a sweep zeroes every entry of the slot store,
//   during which no request is taken (configuration writes still are)
// ----------------------------------------------------------------------------
module dmx512_frame_transmitter (
  input  logic        clk,
  input  logic        rst,
  // request channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  kind,
  input  logic [9:0]  slot,
  input  logic [7:0]  value,
  input  logic        flag,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic        line_level,
  output logic        indicator,
  output logic [7:0]  interval_reload,
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [9:0]  cfg_data
);
  import dmxtx_pkg::*;

  // configuration registers
  logic [9:0] slot_count;
  logic [7:0] break_reload;
  logic [7:0] mab_reload;
  logic [7:0] bit_reload;
  logic [7:0] stop_reload;

  logic       accept;
  logic       clearing;
  logic       full;
  kind_t      kind_in;
  cfg_t       cfg;
  mem_rd_t    rd;
  mem_wr_t    wr;
  logic [7:0] rd_data;
  logic       push;
  result_t    push_data;
  result_t    out_data;

  // config is always taken; writes must only come while the block is idle, which it does not enforce
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_count   <= RST_SLOT_COUNT;
      break_reload <= RST_BREAK_RELOAD;
      mab_reload   <= RST_MAB_RELOAD;
      bit_reload   <= RST_BIT_RELOAD;
      stop_reload  <= RST_STOP_RELOAD;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SLOT_COUNT:   slot_count   <= cfg_data;
        REG_BREAK_RELOAD: break_reload <= cfg_data[7:0];
        REG_MAB_RELOAD:   mab_reload   <= cfg_data[7:0];
        REG_BIT_RELOAD:   bit_reload   <= cfg_data[7:0];
        REG_STOP_RELOAD:  stop_reload  <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  // slot count clamped to 1..SLOTS
  always_comb begin
    if (slot_count == '0) begin
      cfg.count = SLOT_AW'(1);
    end else if (slot_count > SLOT_NUM) begin
      cfg.count = SLOT_NUM;
    end else begin
      cfg.count = slot_count;
    end
    cfg.break_reload = break_reload;
    cfg.mab_reload   = mab_reload;
    cfg.bit_reload   = bit_reload;
    cfg.stop_reload  = stop_reload;
  end

  // requests wait for the store sweep and for room in the output stage
  assign in_ready = !clearing && !full;
  assign accept   = in_valid && in_ready;
  assign kind_in  = kind_t'(kind);

  // slot writes beyond the store are dropped
  assign wr.en   = accept && (kind_in == KIND_WRITE) && (slot < SLOT_NUM);
  assign wr.addr = slot;
  assign wr.data = value;

  dmxtx_slot_mem u_mem (
    .clk      (clk),
    .rst      (rst),
    .wr       (wr),
    .rd       (rd),
    .rd_data  (rd_data),
    .clearing (clearing)
  );

  dmxtx_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .kind      (kind_in),
    .flag      (flag),
    .cfg       (cfg),
    .rd_data   (rd_data),
    .rd        (rd),
    .push      (push),
    .push_data (push_data)
  );

  dmxtx_out_buf u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign line_level      = out_data.line_level;
  assign indicator       = out_data.indicator;
  assign interval_reload = out_data.interval_reload;

endmodule
